>>> sv/shpc_pkg.sv
// Shared constants for the stepper homing and position controller.
package shpc_pkg;

  localparam int unsigned SpmW   = 12;
  localparam int unsigned PosW   = 16;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned StepsW = 28;
  localparam int unsigned CfgW   = 16;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_HOME = 2'd1;
  localparam logic [1:0] ACT_MOVE = 2'd2;

  localparam logic [1:0] CFG_STEPS_PER_MM = 2'd0;
  localparam logic [1:0] CFG_MAX_POSITION = 2'd1;
  localparam logic [1:0] CFG_HOME_HALF    = 2'd2;
  localparam logic [1:0] CFG_BACKOFF      = 2'd3;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_ACCEPTED  = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_HOME_FAIL = 3'd3;
  localparam logic [2:0] ST_HOME_DONE = 3'd4;
  localparam logic [2:0] ST_MOVE_DONE = 3'd5;
  localparam logic [2:0] ST_BUSY      = 3'd6;

  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  localparam logic [SpmW-1:0]  RST_STEPS_PER_MM = 12'd100;
  localparam logic [PosW-1:0]  RST_MAX_POSITION = 16'd1000;
  localparam logic [HalfW-1:0] RST_HOME_HALF    = 16'd500;
  localparam logic [15:0]      RST_BACKOFF      = 16'd15000;

  // A half period of zero behaves as one tick.
  function automatic logic [HalfW-1:0] clamp_half(input logic [HalfW-1:0] p);
    clamp_half = (p == '0) ? HalfW'(1) : p;
  endfunction

endpackage

>>> sv/stepper_homing_position_controller.sv
// Top level of the stepper step/direction controller with homing and moves.
//
// Each input item is either a one-microsecond tick that carries the home
// sensor level, a home command or an absolute move command in millimetres,
// and every item yields exactly one result item with the step and direction
// levels, the busy flag, the position and a status code. The block takes one
// item per clock unless out_stall holds the result: an item is captured in
// an input register, the next control state and the result are formed in one
// pass of logic (the deepest path is the 16 x 12 bit distance times
// steps-per-mm product), and the result lands in an output register. While
// the output register waits on out_stall, the input register still takes an
// item if it is empty. A move that is not rejected sends distance times
// steps_per_mm pulses, each high and then low for the given half period in
// ticks; the position takes the target when the last pulse ends. Homing backs
// off to the right first when it starts on the sensor, fails if the sensor is
// still active after the backoff, then steps left one pulse at a time until
// the sensor reads active and sets the position to zero. Commands that arrive
// while homing or moving are refused with a busy status. Configuration writes
// are expected only while the block is idle.
module stepper_homing_position_controller (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_target_mm,
  input  logic [15:0] in_half_period_us,
  input  logic        in_home_sensor,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_step_level,
  output logic        out_dir_level,
  output logic        out_busy_res,
  output logic [15:0] out_position_mm,
  output logic [2:0]  out_status
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_BACKOFF,
    MODE_SEEK,
    MODE_MOVE
  } mode_t;

  // Configuration registers.
  logic [shpc_pkg::SpmW-1:0]  steps_per_mm_r;
  logic [shpc_pkg::PosW-1:0]  max_position_r;
  logic [shpc_pkg::HalfW-1:0] home_half_r;
  logic [15:0]                backoff_r;

  // Input stage.
  logic                       s1_valid_r;
  logic [1:0]                 s1_action_r;
  logic [15:0]                s1_target_r;
  logic [15:0]                s1_half_r;
  logic                       s1_sensor_r;

  // Control state.
  mode_t                      mode_r, mode_nxt;
  logic [shpc_pkg::PosW-1:0]  position_r, position_nxt;
  logic [shpc_pkg::StepsW-1:0] steps_left_r, steps_left_nxt;
  logic [shpc_pkg::HalfW-1:0] tick_count_r, tick_count_nxt;
  logic [shpc_pkg::HalfW-1:0] half_period_r, half_period_nxt;
  logic                       step_out_r, step_out_nxt;
  logic                       dir_out_r, dir_out_nxt;
  logic [shpc_pkg::PosW-1:0]  target_r, target_nxt;
  logic [2:0]                 status_nxt;

  // Result register.
  logic                       out_valid_r;
  logic                       out_step_r;
  logic                       out_dir_r;
  logic                       out_busy_r;
  logic [15:0]                out_position_r;
  logic [2:0]                 out_status_r;

  logic                       advance;
  logic                       fire;
  logic                       in_take;
  logic                       is_cmd;
  logic [shpc_pkg::HalfW-1:0] tick_inc;
  logic [shpc_pkg::StepsW-1:0] steps_dec;
  logic [shpc_pkg::PosW-1:0]  dist_mm;
  logic [shpc_pkg::StepsW-1:0] move_steps;

  // The pipeline moves whenever the result register is free or being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign is_cmd    = (s1_action_r == shpc_pkg::ACT_HOME) ||
                     (s1_action_r == shpc_pkg::ACT_MOVE);
  assign tick_inc  = tick_count_r + shpc_pkg::HalfW'(1);
  assign steps_dec = (steps_left_r != '0) ?
                     steps_left_r - shpc_pkg::StepsW'(1) : '0;

  // Distance to the target and the number of pulses it takes.
  assign dist_mm = (position_r > s1_target_r) ? position_r - s1_target_r
                                              : s1_target_r - position_r;
  assign move_steps = {12'd0, dist_mm} * {16'd0, steps_per_mm_r};

  always_comb begin
    mode_nxt        = mode_r;
    position_nxt    = position_r;
    steps_left_nxt  = steps_left_r;
    tick_count_nxt  = tick_count_r;
    half_period_nxt = half_period_r;
    step_out_nxt    = step_out_r;
    dir_out_nxt     = dir_out_r;
    target_nxt      = target_r;
    status_nxt      = shpc_pkg::ST_NONE;

    if (is_cmd) begin
      if (mode_r != MODE_IDLE) begin
        status_nxt = shpc_pkg::ST_BUSY;
      end else if (s1_action_r == shpc_pkg::ACT_HOME) begin
        half_period_nxt = shpc_pkg::clamp_half(home_half_r);
        if (s1_sensor_r && backoff_r == '0) begin
          status_nxt = shpc_pkg::ST_HOME_FAIL;
        end else begin
          if (s1_sensor_r) begin
            mode_nxt       = MODE_BACKOFF;
            dir_out_nxt    = shpc_pkg::DIR_RIGHT;
            steps_left_nxt = shpc_pkg::StepsW'(backoff_r);
          end else begin
            mode_nxt       = MODE_SEEK;
            dir_out_nxt    = shpc_pkg::DIR_LEFT;
            steps_left_nxt = shpc_pkg::StepsW'(1);
          end
          step_out_nxt   = 1'b1;
          tick_count_nxt = '0;
          status_nxt     = shpc_pkg::ST_ACCEPTED;
        end
      end else if (s1_target_r > max_position_r) begin
        status_nxt = shpc_pkg::ST_RANGE;
      end else begin
        dir_out_nxt    = (position_r > s1_target_r) ? shpc_pkg::DIR_LEFT
                                                    : shpc_pkg::DIR_RIGHT;
        target_nxt     = s1_target_r;
        steps_left_nxt = move_steps;
        if (move_steps == '0) begin
          // Nothing to step: the move completes on the spot.
          position_nxt = s1_target_r;
          status_nxt   = shpc_pkg::ST_MOVE_DONE;
        end else begin
          half_period_nxt = shpc_pkg::clamp_half(s1_half_r);
          mode_nxt        = MODE_MOVE;
          step_out_nxt    = 1'b1;
          tick_count_nxt  = '0;
          status_nxt      = shpc_pkg::ST_ACCEPTED;
        end
      end
    end else if (mode_r != MODE_IDLE) begin
      // A tick (the unused action code counts as one too).
      if (tick_inc < half_period_r) begin
        tick_count_nxt = tick_inc;
      end else begin
        tick_count_nxt = '0;
        if (step_out_r) begin
          step_out_nxt = 1'b0;
        end else begin
          // A full pulse has ended.
          steps_left_nxt = steps_dec;
          if (mode_r == MODE_SEEK) begin
            if (s1_sensor_r) begin
              position_nxt = '0;
              mode_nxt     = MODE_IDLE;
              status_nxt   = shpc_pkg::ST_HOME_DONE;
            end else begin
              steps_left_nxt = shpc_pkg::StepsW'(1);
              step_out_nxt   = 1'b1;
            end
          end else if (steps_dec != '0) begin
            step_out_nxt = 1'b1;
          end else if (mode_r == MODE_BACKOFF) begin
            if (s1_sensor_r) begin
              mode_nxt   = MODE_IDLE;
              status_nxt = shpc_pkg::ST_HOME_FAIL;
            end else begin
              mode_nxt       = MODE_SEEK;
              dir_out_nxt    = shpc_pkg::DIR_LEFT;
              steps_left_nxt = shpc_pkg::StepsW'(1);
              step_out_nxt   = 1'b1;
            end
          end else begin
            position_nxt = target_r;
            mode_nxt     = MODE_IDLE;
            status_nxt   = shpc_pkg::ST_MOVE_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_per_mm_r <= shpc_pkg::RST_STEPS_PER_MM;
      max_position_r <= shpc_pkg::RST_MAX_POSITION;
      home_half_r    <= shpc_pkg::RST_HOME_HALF;
      backoff_r      <= shpc_pkg::RST_BACKOFF;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      mode_r         <= MODE_IDLE;
      position_r     <= '0;
      steps_left_r   <= '0;
      tick_count_r   <= '0;
      half_period_r  <= '0;
      step_out_r     <= 1'b0;
      dir_out_r      <= 1'b0;
      target_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          shpc_pkg::CFG_STEPS_PER_MM: steps_per_mm_r <= cfg_wdata[shpc_pkg::SpmW-1:0];
          shpc_pkg::CFG_MAX_POSITION: max_position_r <= cfg_wdata;
          shpc_pkg::CFG_HOME_HALF:    home_half_r    <= cfg_wdata;
          shpc_pkg::CFG_BACKOFF:      backoff_r      <= cfg_wdata;
          default:                    backoff_r      <= backoff_r;
        endcase
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r   <= 1'b1;
        mode_r        <= mode_nxt;
        position_r    <= position_nxt;
        steps_left_r  <= steps_left_nxt;
        tick_count_r  <= tick_count_nxt;
        half_period_r <= half_period_nxt;
        step_out_r    <= step_out_nxt;
        dir_out_r     <= dir_out_nxt;
        target_r      <= target_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_target_r <= in_target_mm;
      s1_half_r   <= in_half_period_us;
      s1_sensor_r <= in_home_sensor;
    end
    if (fire) begin
      out_step_r     <= step_out_nxt;
      out_dir_r      <= dir_out_nxt;
      out_busy_r     <= (mode_nxt != MODE_IDLE);
      out_position_r <= position_nxt;
      out_status_r   <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_step_level  = out_step_r;
  assign out_dir_level   = out_dir_r;
  assign out_busy_res    = out_busy_r;
  assign out_position_mm = out_position_r;
  assign out_status      = out_status_r;

  // The step output only rests high while a pulse is in progress.
  a_idle_step_low: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> !step_out_r)
    else $error("step output high while idle");

  // A move in progress always has at least one pulse left.
  a_move_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_MOVE) |-> (steps_left_r != '0))
    else $error("move in progress with no steps left");

  // An accepted command always leaves the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == shpc_pkg::ST_ACCEPTED) |-> out_busy_r)
    else $error("accepted command reported without busy");

  // Completed homing reports an idle block at position zero.
  a_home_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == shpc_pkg::ST_HOME_DONE) |->
      (!out_busy_r && out_position_r == '0))
    else $error("homing done without zero position");

endmodule
